@@ rtl/quant_param_finder_macros.svh @@
// Assertion macros for the quantization parameter finder.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef QUANT_PARAM_FINDER_MACROS_SVH
`define QUANT_PARAM_FINDER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition holds in the same cycle as the trigger.
`define QPF_ASSERT_NOW(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Condition holds in the cycle after the trigger.
`define QPF_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`else

`define QPF_ASSERT_NOW(lbl, trig, cond, msg)
`define QPF_ASSERT_NEXT(lbl, trig, cond, msg)

`endif

`endif

@@ rtl/qpf_pkg.sv @@
package qpf_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_COLUMNS_DEF = 64;
    localparam int FRAC_BITS_DEF   = 12;

    // Fixed field widths.
    localparam int WEIGHT_W  = 16;
    localparam int COL_W     = 6;
    localparam int SCALE_W   = 33;
    localparam int ZP_W      = 8;
    localparam int LVL_W     = 8;
    localparam int NCOL_W    = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    // Range of clamped bounds, up to 2^16, and its scale dividend shift base.
    localparam int RANGE_W   = 17;
    localparam int SCALE_FB  = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMMETRIC    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS_USED = 2'd2;

    // Register values after reset.
    localparam logic [LVL_W-1:0]  MAX_LEVEL_RST    = 8'd15;
    localparam logic              SYMMETRIC_RST    = 1'b0;
    localparam logic [NCOL_W-1:0] COLUMNS_USED_RST = 7'd64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_RD,
        S_LOAD,
        S_MUL,
        S_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic acc_capture;
        logic acc_write;
        logic rd_from_input;
        logic col_clear;
        logic load_bounds;
        logic mul_start;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic item_last;
        logic cols_zero;
        logic div_last;
        logic col_last;
    } t_status;

endpackage

@@ rtl/qpf_ram.sv @@
module qpf_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/qpf_ctrl.sv @@
module qpf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_stall,
    input  qpf_pkg::t_status i_status,
    output qpf_pkg::t_cmd    o_cmd,
    output logic             o_in_stall,
    output logic             o_out_valid
);

    import qpf_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_UPD;
            end
            S_UPD: begin
                if (i_status.item_last && !i_status.cols_zero) n_state = S_RD;
                else n_state = S_IDLE;
            end
            S_RD:   n_state = S_LOAD;
            S_LOAD: n_state = S_MUL;
            S_MUL:  n_state = S_DIV;
            S_DIV: begin
                if (i_status.div_last) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (slot_free) n_state = i_status.col_last ? S_IDLE : S_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall          = 1'b0;
                o_cmd.rd_from_input = 1'b1;
                o_cmd.acc_capture   = i_in_valid;
            end
            S_UPD: begin
                o_cmd.acc_write = 1'b1;
                o_cmd.col_clear = 1'b1;
            end
            S_RD:   o_cmd = '0;
            S_LOAD: o_cmd.load_bounds = 1'b1;
            S_MUL:  o_cmd.mul_start = 1'b1;
            S_DIV:  o_cmd.div_step = 1'b1;
            S_EMIT: o_cmd.out_load = slot_free;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) n_out_valid = 1'b1;
        else if (!i_out_stall) n_out_valid = 1'b0;
        else n_out_valid = r_out_valid;
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/qpf_datapath.sv @@
module qpf_datapath #(
    parameter int MAX_COLUMNS = qpf_pkg::MAX_COLUMNS_DEF,
    parameter int FRAC_BITS   = qpf_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  qpf_pkg::t_cmd                         i_cmd,
    output qpf_pkg::t_status                      o_status,
    input  logic signed [qpf_pkg::WEIGHT_W-1:0]   i_weight_value,
    input  logic [qpf_pkg::COL_W-1:0]             i_column_index,
    input  logic                                  i_first_row,
    input  logic                                  i_last_element,
    input  logic                                  i_cfg_we,
    input  logic [qpf_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [qpf_pkg::CFG_DAT_W-1:0]         i_cfg_data,
    output logic [qpf_pkg::COL_W-1:0]             o_out_column,
    output logic [qpf_pkg::SCALE_W-1:0]           o_scale_value,
    output logic [qpf_pkg::ZP_W-1:0]              o_zero_point,
    output logic                                  o_last_column
);

    import qpf_pkg::*;

    localparam int ADDR_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int MEM_W  = 2 * WEIGHT_W;
    localparam int DIVW   = RANGE_W + SCALE_FB - FRAC_BITS;
    localparam int CNT_W  = $clog2(DIVW);
    localparam int ZN_W   = RANGE_W + LVL_W + 1;
    localparam int BND_W  = WEIGHT_W + 2;

    // Configuration registers.
    logic [LVL_W-1:0]  r_max_level;
    logic              r_symmetric;
    logic [NCOL_W-1:0] r_columns_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_level    <= MAX_LEVEL_RST;
            r_symmetric    <= SYMMETRIC_RST;
            r_columns_used <= COLUMNS_USED_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MAX_LEVEL:    r_max_level    <= i_cfg_data;
                REG_SYMMETRIC:    r_symmetric    <= i_cfg_data[0];
                REG_COLUMNS_USED: r_columns_used <= i_cfg_data[NCOL_W-1:0];
                default:          r_max_level    <= r_max_level;
            endcase
        end
    end

    logic [LVL_W-1:0]  lvl;
    logic [NCOL_W-1:0] ncols;

    assign lvl   = (r_max_level == '0) ? LVL_W'(1) : r_max_level;
    assign ncols = (r_columns_used > NCOL_W'(MAX_COLUMNS)) ? NCOL_W'(MAX_COLUMNS)
                                                          : r_columns_used;

    // Latched request.
    logic signed [WEIGHT_W-1:0] r_w;
    logic [COL_W-1:0]           r_col;
    logic                       r_first;
    logic                       r_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_capture) begin
            r_w     <= i_weight_value;
            r_col   <= i_column_index;
            r_first <= i_first_row;
            r_last  <= i_last_element;
        end
    end

    // Bounds memory: maximum in the upper half, minimum in the lower half.
    logic [NCOL_W-1:0]   r_k;
    logic [ADDR_W-1:0]   raddr;
    logic [MEM_W-1:0]    rdata;
    logic [MEM_W-1:0]    wdata;
    logic                we;
    logic signed [WEIGHT_W-1:0] m_min, m_max, u_min, u_max;

    assign raddr = i_cmd.rd_from_input ? i_column_index[ADDR_W-1:0] : r_k[ADDR_W-1:0];
    assign m_min = $signed(rdata[WEIGHT_W-1:0]);
    assign m_max = $signed(rdata[MEM_W-1:WEIGHT_W]);

    always_comb begin
        if (r_first) begin
            u_min = r_w;
            u_max = r_w;
        end else begin
            u_min = (r_w < m_min) ? r_w : m_min;
            u_max = (r_w > m_max) ? r_w : m_max;
        end
    end

    assign wdata = {u_max, u_min};
    assign we    = i_cmd.acc_write && ({1'b0, r_col} < NCOL_W'(MAX_COLUMNS));

    qpf_ram #(
        .WIDTH  (MEM_W),
        .DEPTH  (MAX_COLUMNS),
        .ADDR_W (ADDR_W)
    ) u_bounds_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_col[ADDR_W-1:0]),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Column counter for the emission pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (i_cmd.col_clear) begin
            r_k <= '0;
        end else if (i_cmd.out_load) begin
            r_k <= r_k + NCOL_W'(1);
        end
    end

    // Clamp, symmetric fold and zero-range widening.
    logic signed [BND_W-1:0] mn0, mx0, mn1, mx1, mn2, mx2, mag;
    logic [RANGE_W-1:0]      range_c, negmn_c;

    always_comb begin
        mn0 = (m_min > 0) ? '0 : BND_W'(m_min);
        mx0 = (m_max < 0) ? '0 : BND_W'(m_max);
        mag = -mn0;
        mn1 = mn0;
        mx1 = mx0;
        if (r_symmetric) begin
            if (mag > mx0) mx1 = mag;
            if (mn0 < 0) mn1 = -mx1;
        end
        mn2 = mn1;
        mx2 = mx1;
        if (mn1 == 0 && mx1 == 0) begin
            mn2 = -(BND_W'(1) <<< FRAC_BITS);
            mx2 = BND_W'(1) <<< FRAC_BITS;
        end
        range_c = RANGE_W'(mx2 - mn2);
        negmn_c = RANGE_W'(-mn2);
    end

    logic [RANGE_W-1:0] r_range, r_negmn;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_bounds) begin
            r_range <= range_c;
            r_negmn <= negmn_c;
        end
    end

    // Dividers: scale runs one quotient bit a cycle, the zero point joins once
    // r_cnt is below ZP_W, as its quotient never exceeds the level in use.
    logic [RANGE_W+LVL_W-1:0] prod;
    logic [ZN_W-1:0]          numer;
    logic [CNT_W-1:0]         r_cnt;
    logic [DIVW-1:0]          r_sc_q;
    logic [LVL_W-1:0]         r_sc_rem;
    logic [ZN_W-1:0]          r_zp_rem, r_zp_div;
    logic [ZP_W-1:0]          r_zp_q;
    logic [LVL_W:0]           sc_try;
    logic                     sc_bit, zp_bit;

    assign prod   = r_negmn * lvl;
    assign numer  = {prod, 1'b0} + ZN_W'(r_range);
    assign sc_try = {r_sc_rem, r_sc_q[DIVW-1]};
    assign sc_bit = sc_try >= {1'b0, lvl};
    assign zp_bit = r_zp_rem >= r_zp_div;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_cnt    <= CNT_W'(DIVW - 1);
            r_sc_q   <= DIVW'(r_range) << (SCALE_FB - FRAC_BITS);
            r_sc_rem <= '0;
            r_zp_rem <= numer;
            r_zp_div <= ZN_W'({r_range, {ZP_W{1'b0}}});
            r_zp_q   <= '0;
        end else if (i_cmd.div_step) begin
            r_cnt    <= r_cnt - CNT_W'(1);
            r_sc_q   <= {r_sc_q[DIVW-2:0], sc_bit};
            r_sc_rem <= sc_bit ? LVL_W'(sc_try - {1'b0, lvl}) : sc_try[LVL_W-1:0];
            if (r_cnt < CNT_W'(ZP_W)) begin
                r_zp_q   <= {r_zp_q[ZP_W-2:0], zp_bit};
                r_zp_rem <= zp_bit ? (r_zp_rem - r_zp_div) : r_zp_rem;
                r_zp_div <= r_zp_div >> 1;
            end
        end
    end

    // Output register.
    logic [LVL_W:0] half_lvl;
    logic           col_last;

    assign half_lvl = ({1'b0, lvl} + (LVL_W+1)'(1)) >> 1;
    assign col_last = (r_k + NCOL_W'(1)) == ncols;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_column  <= r_k[COL_W-1:0];
            o_scale_value <= SCALE_W'(r_sc_q);
            o_zero_point  <= r_symmetric ? half_lvl[ZP_W-1:0] : r_zp_q;
            o_last_column <= col_last;
        end
    end

    assign o_status.item_last = r_last;
    assign o_status.cols_zero = (ncols == '0);
    assign o_status.div_last  = (r_cnt == '0);
    assign o_status.col_last  = col_last;

endmodule

@@ rtl/quant_param_finder.sv @@
// Min/max affine quantization parameter finder, one channel per weight column.
// Input channel: one request carries a signed Q3.12 weight, its column, a
// first-row flag that seeds the column bounds and a last flag. A request is
// taken when i_in_valid is high and o_in_stall is low; its column bounds are
// read from the memory as it is taken and written back in the update state.
// A request marked last starts the emission pass: for columns 0 up to
// columns_used-1 (at most MAX_COLUMNS-1) the block sends one result request
// with the scale (16 fraction bits) and the zero point. The scale divider
// gives one quotient bit per cycle. No input is taken during the pass.
// Results leave through an output register, so the last result may wait
// while new weights arrive. When i_out_stall is high the waiting result
// holds and the pass waits to load the next one. Configuration must be
// written through i_cfg_we/i_cfg_index/i_cfg_data while idle; the block
// does not enforce this. Reset sets max_level to 15, symmetric to 0,
// columns_used to 64 and clears the controller; the bounds memory is not
// cleared and a column must see its first row before it is read.
`include "quant_param_finder_macros.svh"

module quant_param_finder #(
    parameter int MAX_COLUMNS = qpf_pkg::MAX_COLUMNS_DEF,
    parameter int FRAC_BITS   = qpf_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input requests.
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [qpf_pkg::WEIGHT_W-1:0] i_weight_value,
    input  logic [qpf_pkg::COL_W-1:0]           i_column_index,
    input  logic                                i_first_row,
    input  logic                                i_last_element,
    // Result requests.
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [qpf_pkg::COL_W-1:0]           o_out_column,
    output logic [qpf_pkg::SCALE_W-1:0]         o_scale_value,
    output logic [qpf_pkg::ZP_W-1:0]            o_zero_point,
    output logic                                o_last_column,
    // Configuration writes.
    input  logic                                i_cfg_we,
    input  logic [qpf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [qpf_pkg::CFG_DAT_W-1:0]       i_cfg_data
);

    import qpf_pkg::*;

    t_cmd    cmd;
    t_status status;

    // The controller sequences accumulation and the per-column emission pass.
    qpf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // The datapath holds the configuration, the bounds memory, the
    // clamping logic, both dividers and the output register.
    qpf_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_weight_value (i_weight_value),
        .i_column_index (i_column_index),
        .i_first_row    (i_first_row),
        .i_last_element (i_last_element),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_out_column   (o_out_column),
        .o_scale_value  (o_scale_value),
        .o_zero_point   (o_zero_point),
        .o_last_column  (o_last_column)
    );

    // An accepted weight always spends the next cycle on the memory write.
    `QPF_ASSERT_NEXT(a_busy_after_req, i_in_valid && !o_in_stall, o_in_stall, "input taken during update")

    // The output register is only loaded when the previous result is gone.
    `QPF_ASSERT_NOW(a_load_slot_free, cmd.out_load, !o_out_valid || !i_out_stall, "result overwritten")

    // A captured request is always followed by its bounds write.
    `QPF_ASSERT_NEXT(a_capture_then_write, cmd.acc_capture, cmd.acc_write, "bounds write missing")

endmodule

@@ dv/tb.sv @@
module tb;
    import qpf_pkg::*;

    localparam int MAX_COLS = MAX_COLUMNS_DEF;
    localparam int FRAC     = FRAC_BITS_DEF;
    // Time allowed for one column of the emission pass.
    localparam int COLUMN_CYCLES = 4 + (SCALE_W - FRAC);
    // Quiet time before a register write and at the end of the run.
    localparam int SETTLE = 2 * COLUMN_CYCLES;

    typedef struct packed {
        logic [COL_W-1:0]   column;
        logic [SCALE_W-1:0] scale;
        logic [ZP_W-1:0]    zp;
        logic               last_col;
    } t_param;

    typedef enum {STEP_CFG, STEP_ITEM} t_step_kind;

    typedef struct {
        t_step_kind                 kind;
        logic [CFG_IDX_W-1:0]       reg_idx;
        logic [CFG_DAT_W-1:0]       reg_data;
        logic signed [WEIGHT_W-1:0] weight;
        logic [COL_W-1:0]           column;
        logic                       first;
        logic                       last;
        logic                       typed;
        logic [SCALE_W-1:0]         scale;
        logic [ZP_W-1:0]            zp;
    } t_step;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic signed [WEIGHT_W-1:0] i_weight_value;
    logic [COL_W-1:0]           i_column_index;
    logic                       i_first_row;
    logic                       i_last_element;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic [COL_W-1:0]           o_out_column;
    logic [SCALE_W-1:0]         o_scale_value;
    logic [ZP_W-1:0]            o_zero_point;
    logic                       o_last_column;
    logic                       i_cfg_we;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [CFG_DAT_W-1:0]       i_cfg_data;

    quant_param_finder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_weight_value (i_weight_value),
        .i_column_index (i_column_index),
        .i_first_row    (i_first_row),
        .i_last_element (i_last_element),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_column   (o_out_column),
        .o_scale_value  (o_scale_value),
        .o_zero_point   (o_zero_point),
        .o_last_column  (o_last_column),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the per-column bounds and of the three registers.
    logic signed [WEIGHT_W-1:0] bound_lo [MAX_COLS];
    logic signed [WEIGHT_W-1:0] bound_hi [MAX_COLS];
    logic [LVL_W-1:0]           cfg_level;
    logic                       cfg_sym;
    logic [NCOL_W-1:0]          cfg_ncol;

    // Parameters still owed by the block, oldest first.
    t_param params_due[$];
    t_param want;
    int     mismatches;

    // Idling percentages for the two sides, and a long output hold-off
    // requested by the main sequence and counted down by the receiver.
    int send_idle_pct;
    int stall_pct;
    int hold_request;
    int hold_left;

    t_step plan[$];
    t_step s_row;
    t_param typed_want;
    int p;
    int c;
    t_idle_mode mode;

    // Folds one accepted weight into the shadow bounds. When the request
    // is marked last, works out the scale and zero point of every column
    // in use and queues them in emission order.
    function automatic void predict_params(input logic signed [WEIGHT_W-1:0] w,
                                           input logic [COL_W-1:0] col,
                                           input logic first, input logic last);
        longint lo, hi, mag, span, neg, lvl;
        int n, k;
        t_param r;
        if (first) begin
            bound_lo[col] = w;
            bound_hi[col] = w;
        end else begin
            if (w < bound_lo[col]) bound_lo[col] = w;
            if (w > bound_hi[col]) bound_hi[col] = w;
        end
        if (!last) return;
        // A column count above the memory depth saturates; a level of zero
        // behaves as a level of one.
        n = (cfg_ncol > MAX_COLS) ? MAX_COLS : int'(cfg_ncol);
        lvl = (cfg_level == 0) ? 1 : longint'(cfg_level);
        for (k = 0; k < n; k++) begin
            lo = bound_lo[k];
            hi = bound_hi[k];
            if (lo > 0) lo = 0;
            if (hi < 0) hi = 0;
            if (cfg_sym) begin
                mag = -lo;
                if (mag > hi) hi = mag;
                if (lo < 0) lo = -hi;
            end
            // An all-zero column is widened to plus and minus one.
            if (lo == 0 && hi == 0) begin
                lo = -(longint'(1) << FRAC);
                hi = longint'(1) << FRAC;
            end
            span = hi - lo;
            neg = -lo;
            r.column = COL_W'(k);
            r.scale = SCALE_W'((span << (16 - FRAC)) / lvl);
            if (cfg_sym)
                r.zp = ZP_W'((lvl + 1) / 2);
            else
                r.zp = ZP_W'((2 * neg * lvl + span) / (2 * span));
            r.last_col = (k + 1 == n);
            params_due.push_back(r);
        end
    endfunction

    function automatic t_step cfg_step(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DAT_W-1:0] data);
        t_step s;
        s.kind = STEP_CFG;
        s.reg_idx = idx;
        s.reg_data = data;
        s.typed = 1'b0;
        return s;
    endfunction

    function automatic t_step item_step(input logic signed [WEIGHT_W-1:0] w,
                                        input logic [COL_W-1:0] col,
                                        input logic first, input logic last);
        t_step s;
        s.kind = STEP_ITEM;
        s.weight = w;
        s.column = col;
        s.first = first;
        s.last = last;
        s.typed = 1'b0;
        return s;
    endfunction

    // A request whose single result (column 0 of a one-column pass) is known.
    function automatic t_step checked_step(input logic signed [WEIGHT_W-1:0] w,
                                           input logic first,
                                           input logic [SCALE_W-1:0] scale,
                                           input logic [ZP_W-1:0] zp);
        t_step s;
        s = item_step(w, '0, first, 1'b1);
        s.typed = 1'b1;
        s.scale = scale;
        s.zp = zp;
        return s;
    endfunction

    function automatic logic signed [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 16'sh8000;
            2: return 16'sh7fff;
            3: return WEIGHT_W'(int'($urandom_range(0, 128)) - 64);
            default: return WEIGHT_W'($urandom);
        endcase
    endfunction

    // Presents one input request and returns at the edge that takes it.
    // The payload stays put while the block stalls.
    task automatic offer(input logic signed [WEIGHT_W-1:0] w, input logic [COL_W-1:0] col,
                         input logic first, input logic last);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_weight_value = w;
        i_column_index = col;
        i_first_row = first;
        i_last_element = last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_params(w, col, first, last);
    endtask

    // Drops the input, waits for every owed result, then lets the block
    // finish whatever it may still be doing.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (params_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        settle();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_MAX_LEVEL:    cfg_level = data;
            REG_SYMMETRIC:    cfg_sym = data[0];
            REG_COLUMNS_USED: cfg_ncol = data[NCOL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_phase(input int lvl, input int sym, input int ncol,
                             input t_idle_mode m);
        write_reg(REG_MAX_LEVEL, CFG_DAT_W'(lvl));
        write_reg(REG_SYMMETRIC, CFG_DAT_W'(sym));
        write_reg(REG_COLUMNS_USED, CFG_DAT_W'(ncol));
        send_idle_pct = (m == IDLE_SEND) ? 79 : (m == IDLE_BOTH) ? 36 : 0;
        stall_pct     = (m == IDLE_RECV) ? 79 : (m == IDLE_BOTH) ? 36 : 0;
    endtask

    // One weight matrix: a seeding first row over a run of adjacent
    // columns, further rows folded in, and the last flag on its final
    // element. Stray requests are mixed in. Some matrices skip the first
    // row and keep stale bounds, and some end early.
    task automatic send_matrix();
        int cols, rows, base, stop_at, n;
        logic seeded;
        cols = $urandom_range(1, 8);
        rows = $urandom_range(1, 3);
        base = $urandom_range(0, MAX_COLS - 1);
        seeded = ($urandom_range(0, 7) != 0);
        stop_at = cols * rows - 1;
        if ($urandom_range(0, 7) == 0) stop_at = $urandom_range(0, stop_at);
        for (n = 0; n <= stop_at; n++) begin
            if ($urandom_range(0, 99) < 15)
                offer(pick_weight(), COL_W'($urandom_range(0, MAX_COLS - 1)),
                      1'($urandom_range(0, 1)), 1'b0);
            offer(pick_weight(), COL_W'((base + n % cols) % MAX_COLS),
                  seeded && (n < cols), n == stop_at);
        end
    endtask

    // Output side: random stalls at the current rate, or a long hold-off
    // when the main sequence asks for one.
    initial begin
        i_out_stall = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left--;
            end else begin
                i_out_stall = ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Every result request the block hands over is matched against the
    // oldest owed one, field by field.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (params_due.size() == 0) begin
                $display("%0t: result expected none, got column %0d",
                         $time, o_out_column);
                mismatches++;
            end else begin
                want = params_due.pop_front();
                if (o_out_column !== want.column) begin
                    $display("%0t: column expected %0d, got %0d",
                             $time, want.column, o_out_column);
                    mismatches++;
                end
                if (o_scale_value !== want.scale) begin
                    $display("%0t: column %0d scale expected %0d, got %0d",
                             $time, want.column, want.scale, o_scale_value);
                    mismatches++;
                end
                if (o_zero_point !== want.zp) begin
                    $display("%0t: column %0d zero point expected %0d, got %0d",
                             $time, want.column, want.zp, o_zero_point);
                    mismatches++;
                end
                if (o_last_column !== want.last_col) begin
                    $display("%0t: column %0d last flag expected %0b, got %0b",
                             $time, want.column, want.last_col, o_last_column);
                    mismatches++;
                end
            end
        end
    end

    // Hard stop far beyond the slowest legal run.
    initial begin
        #10000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_weight_value = '0;
        i_column_index = '0;
        i_first_row = 1'b0;
        i_last_element = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_MAX_LEVEL;
        i_cfg_data = '0;
        mismatches = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_request = 0;
        cfg_level = MAX_LEVEL_RST;
        cfg_sym = SYMMETRIC_RST;
        cfg_ncol = COLUMNS_USED_RST;
        for (c = 0; c < MAX_COLS; c++) begin
            bound_lo[c] = '0;
            bound_hi[c] = '0;
        end

        // Directed requests. The first five run at the reset level of 15,
        // asymmetric, with a single column in use: an all-zero column, the
        // largest and the most negative weight alone, and both together.
        plan.push_back(cfg_step(REG_COLUMNS_USED, 8'd1));
        plan.push_back(checked_step(16'sd0, 1'b1, 33'd8738, 8'd8));
        plan.push_back(checked_step(16'sh7fff, 1'b1, 33'd34951, 8'd0));
        plan.push_back(checked_step(16'sh8000, 1'b1, 33'd34952, 8'd15));
        plan.push_back(item_step(16'sh8000, 6'd0, 1'b1, 1'b0));
        plan.push_back(checked_step(16'sh7fff, 1'b0, 33'd69904, 8'd8));
        // Three columns, two of them with bounds built over two rows.
        plan.push_back(cfg_step(REG_COLUMNS_USED, 8'd3));
        plan.push_back(item_step(16'sd100, 6'd1, 1'b1, 1'b0));
        plan.push_back(item_step(-16'sd5, 6'd2, 1'b1, 1'b0));
        plan.push_back(item_step(-16'sd200, 6'd1, 1'b0, 1'b0));
        plan.push_back(item_step(16'sd1, 6'd2, 1'b0, 1'b0));
        plan.push_back(item_step(16'sd4096, 6'd0, 1'b1, 1'b1));
        // No columns in use: the last flag produces nothing.
        plan.push_back(cfg_step(REG_COLUMNS_USED, 8'd0));
        plan.push_back(item_step(16'sd7, 6'd0, 1'b0, 1'b1));
        // Symmetric at the top level, then at a level of zero.
        plan.push_back(cfg_step(REG_SYMMETRIC, 8'd1));
        plan.push_back(cfg_step(REG_MAX_LEVEL, 8'd255));
        plan.push_back(cfg_step(REG_COLUMNS_USED, 8'd1));
        plan.push_back(checked_step(-16'sd4096, 1'b1, 33'd514, 8'd128));
        plan.push_back(checked_step(16'sh8000, 1'b1, 33'd4112, 8'd128));
        plan.push_back(cfg_step(REG_MAX_LEVEL, 8'd0));
        plan.push_back(checked_step(16'sd123, 1'b1, 33'd1968, 8'd1));
        plan.push_back(cfg_step(REG_SYMMETRIC, 8'd0));
        plan.push_back(checked_step(16'sd4096, 1'b1, 33'd65536, 8'd0));
        plan.push_back(checked_step(-16'sd1, 1'b1, 33'd16, 8'd1));
        // The highest column, then a two-column pass.
        plan.push_back(cfg_step(REG_COLUMNS_USED, 8'd2));
        plan.push_back(item_step(16'sh8000, 6'd63, 1'b1, 1'b0));
        plan.push_back(item_step(16'sh7fff, 6'd63, 1'b0, 1'b0));
        plan.push_back(item_step(16'sd1, 6'd1, 1'b0, 1'b1));

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[i]) begin
            s_row = plan[i];
            if (s_row.kind == STEP_CFG) begin
                write_reg(s_row.reg_idx, s_row.reg_data);
            end else begin
                offer(s_row.weight, s_row.column, s_row.first, s_row.last);
                if (s_row.typed) begin
                    // The one queued result of this request is replaced by
                    // the value worked out by hand.
                    void'(params_due.pop_back());
                    typed_want.column = '0;
                    typed_want.scale = s_row.scale;
                    typed_want.zp = s_row.zp;
                    typed_want.last_col = 1'b1;
                    params_due.push_back(typed_want);
                end
            end
        end

        // Seed every column's bounds so that any column count is legal from
        // here on. The count written is above the depth and saturates.
        set_phase(255, 0, 100, IDLE_BOTH);
        for (c = 0; c < MAX_COLS; c++)
            offer(pick_weight(), COL_W'(c), 1'b1, c == MAX_COLS - 1);

        for (p = 0; p < 4; p++) begin
            mode = t_idle_mode'(p);
            set_phase((p == 1) ? 255 : (p == 2) ? 1 : $urandom_range(1, 255),
                      (p < 2) ? p : $urandom_range(0, 1),
                      (p == 0) ? 8 : (p == 2) ? 127 : (p == 3) ? 64 : $urandom_range(1, 6),
                      mode);
            send_matrix();
            if (p == 0) begin
                // The pass has just been triggered: hold the output back
                // long enough that the block fills and stalls its input
                // while more requests keep coming.
                hold_request = 300;
                send_matrix();
            end
            if (p == 2) begin
                // Let the block run dry before going on.
                settle();
            end
        end

        send_idle_pct = 0;
        stall_pct = 0;
        settle();
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/qpf_pkg.sv
rtl/qpf_ram.sv
rtl/qpf_ctrl.sv
rtl/qpf_datapath.sv
rtl/quant_param_finder.sv
dv/tb.sv
